// ===== sv/hcr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hcr_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int MAX_RUN_DEF     = 64;

  localparam int PHASE_W   = 16;
  localparam int STEP_W    = PHASE_W + 1;
  localparam int PHASE_ONE = 1 << PHASE_W;
  localparam logic [STEP_W-1:0] STEP_RESET = 17'd6087;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 1'b1;

  localparam int SEEN_W = 2;
  localparam logic [SEEN_W-1:0] SEEN_FULL = 2'd3;

  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] UPC_COEF = 4'd0;
  localparam logic [UPC_W-1:0] UPC_LOOP = 4'd1;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_COEF,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_FIX,
    OP_EMIT
  } mc_op_e;

  typedef enum logic {
    OPND_A2,
    OPND_VAL
  } opnd_e;

  typedef enum logic [1:0] {
    ADD_NEG_B2,
    ADD_C2,
    ADD_X0
  } addend_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_LOOP,
    JMP_HALT
  } jump_e;

  typedef struct packed {
    mc_op_e            op;
    opnd_e             opnd;
    addend_e           addend;
    logic              shift16;
    jump_e             jump;
    logic [UPC_W-1:0]  target;
  } mc_word_t;

  localparam mc_word_t MC_IDLE = '{op: OP_NOP, opnd: OPND_A2, addend: ADD_C2,
                                   shift16: 1'b0, jump: JMP_HALT, target: UPC_COEF};

  // One result: coefficients once per item, then three multiply-accumulate
  // passes of Horner's rule over the phase, then the output step.
  function automatic mc_word_t mc_rom(input logic [UPC_W-1:0] upc);
    mc_word_t w;
    w = MC_IDLE;
    unique case (upc)
      4'd0: w = '{op: OP_COEF, opnd: OPND_A2, addend: ADD_C2, shift16: 1'b0,
                  jump: JMP_NEXT, target: UPC_COEF};
      4'd1: w = '{op: OP_MUL_LO, opnd: OPND_A2, addend: ADD_C2, shift16: 1'b0,
                  jump: JMP_NEXT, target: UPC_COEF};
      4'd2: w = '{op: OP_MUL_HI, opnd: OPND_A2, addend: ADD_C2, shift16: 1'b0,
                  jump: JMP_NEXT, target: UPC_COEF};
      4'd3: w = '{op: OP_FIX, opnd: OPND_A2, addend: ADD_NEG_B2, shift16: 1'b0,
                  jump: JMP_NEXT, target: UPC_COEF};
      4'd4: w = '{op: OP_MUL_LO, opnd: OPND_VAL, addend: ADD_C2, shift16: 1'b0,
                  jump: JMP_NEXT, target: UPC_COEF};
      4'd5: w = '{op: OP_MUL_HI, opnd: OPND_VAL, addend: ADD_C2, shift16: 1'b0,
                  jump: JMP_NEXT, target: UPC_COEF};
      4'd6: w = '{op: OP_FIX, opnd: OPND_VAL, addend: ADD_C2, shift16: 1'b1,
                  jump: JMP_NEXT, target: UPC_COEF};
      4'd7: w = '{op: OP_MUL_LO, opnd: OPND_VAL, addend: ADD_X0, shift16: 1'b0,
                  jump: JMP_NEXT, target: UPC_COEF};
      4'd8: w = '{op: OP_MUL_HI, opnd: OPND_VAL, addend: ADD_X0, shift16: 1'b0,
                  jump: JMP_NEXT, target: UPC_COEF};
      4'd9: w = '{op: OP_FIX, opnd: OPND_VAL, addend: ADD_X0, shift16: 1'b1,
                  jump: JMP_NEXT, target: UPC_COEF};
      4'd10: w = '{op: OP_EMIT, opnd: OPND_VAL, addend: ADD_X0, shift16: 1'b0,
                   jump: JMP_LOOP, target: UPC_LOOP};
      default: w = MC_IDLE;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== sv/hcr_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface hcr_in_if #(
  parameter int SAMPLE_W = 16
);
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                       first_sample;
  logic                       final_sample;

  modport source (output valid, output sample_value, output first_sample,
                  output final_sample, input ready);
  modport sink (input valid, input sample_value, input first_sample,
                input final_sample, output ready);
endinterface

`default_nettype wire

// ===== sv/hcr_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface hcr_out_if #(
  parameter int SAMPLE_W = 16,
  parameter int INDEX_W  = 12
);
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_value;
  logic [INDEX_W-1:0]         out_index;
  logic                       run_last;
  logic                       table_end;
  logic                       source_consumed;

  modport source (output valid, output out_value, output out_index, output run_last,
                  output table_end, output source_consumed, input ready);
  modport sink (input valid, input out_value, input out_index, input run_last,
                input table_end, input source_consumed, output ready);
endinterface

`default_nettype wire

// ===== sv/hcr_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface hcr_cfg_if;
  import hcr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/hcr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hcr_datapath #(
  parameter int SAMPLE_BITS = hcr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  hcr_pkg::mc_word_t             ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] win_i [4],
  input  logic [hcr_pkg::PHASE_W-1:0]   phase_i,
  output logic signed [SAMPLE_BITS-1:0] value_o
);
  import hcr_pkg::*;

  localparam int CW     = SAMPLE_BITS + 5;
  localparam int VAL_W  = SAMPLE_BITS + 15;
  localparam int PROD_W = VAL_W + 9;
  localparam int ACC_W  = VAL_W + 17;
  localparam logic signed [VAL_W-1:0] SAT_HI =
    {{(VAL_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [VAL_W-1:0] SAT_LO =
    {{(VAL_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

  logic signed [CW-1:0]     xm1, x0, x1, x2, c2, v, w2, a2, b2;
  logic signed [CW-1:0]     a2_q, b2_q, c2_q, x0_q;
  logic signed [VAL_W-1:0]  val_q, opnd, addend, fixed, rsum, rsh;
  logic signed [8:0]        tbyte;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext, acc_q, acc_sh;

  assign xm1 = CW'(win_i[0]);
  assign x0  = CW'(win_i[1]);
  assign x1  = CW'(win_i[2]);
  assign x2  = CW'(win_i[3]);
  assign c2  = x1 - xm1;
  assign v   = x0 - x1;
  assign w2  = c2 + (v <<< 1);
  assign a2  = w2 + (v <<< 1) + (x2 - x0);
  assign b2  = w2 + a2;

  assign opnd  = (ctrl_i.opnd == OPND_A2) ? VAL_W'(a2_q) : val_q;
  assign tbyte = (ctrl_i.op == OP_MUL_HI) ? $signed({1'b0, phase_i[15:8]})
                                          : $signed({1'b0, phase_i[7:0]});
  assign prod     = opnd * tbyte;
  assign prod_ext = ACC_W'(prod);
  assign acc_sh   = ctrl_i.shift16 ? (acc_q >>> 16) : (acc_q >>> 8);

  always_comb begin
    unique case (ctrl_i.addend)
      ADD_NEG_B2: addend = (-VAL_W'(b2_q)) <<< 8;
      ADD_C2:     addend = VAL_W'(c2_q) <<< 8;
      ADD_X0:     addend = VAL_W'(x0_q) <<< 9;
      default:    addend = '0;
    endcase
  end

  assign fixed = VAL_W'(acc_sh) + addend;

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      OP_COEF: begin
        a2_q <= a2;
        b2_q <= b2;
        c2_q <= c2;
        x0_q <= x0;
      end
      OP_MUL_LO: acc_q <= prod_ext;
      OP_MUL_HI: acc_q <= acc_q + (prod_ext <<< 8);
      OP_FIX:    val_q <= fixed;
      default: begin
      end
    endcase
  end

  assign rsum = val_q + VAL_W'(256);
  assign rsh  = rsum >>> 9;

  always_comb begin
    priority if (rsh > SAT_HI) begin
      value_o = SAT_HI[SAMPLE_BITS-1:0];
    end else if (rsh < SAT_LO) begin
      value_o = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      value_o = rsh[SAMPLE_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/hermite_cubic_resampler_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Four-point cubic Hermite resampler that fills a table of up to TABLE_DEPTH results from a
// stream of Q1.15 samples, stepping a UQ0.16 phase by the clamped phase_step per result. The
// input is not ready again until the last result of that item has been loaded into the
// output register, and an item that causes no results is done in the cycle it is accepted.
// A microcoded sequencer runs every result through one shared multiplier, which takes
// the phase a byte at a time over three Horner passes.
module hermite_cubic_resampler_top #(
  parameter int SAMPLE_BITS = hcr_pkg::SAMPLE_BITS_DEF,
  parameter int TABLE_DEPTH = hcr_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_RUN     = hcr_pkg::MAX_RUN_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hcr_cfg_if.sink   cfg_i,
  hcr_in_if.sink    in_i,
  hcr_out_if.source out_o
);
  import hcr_pkg::*;

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int LIMIT_W = IDX_W + 1;
  localparam int RUN_W   = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam logic [STEP_W-1:0] MIN_STEP = STEP_W'((PHASE_ONE + MAX_RUN - 1) / MAX_RUN);

  logic [STEP_W-1:0]  step_q, step_eff;
  logic [LIMIT_W-1:0] limit_q, limit_eff;

  logic signed [SAMPLE_BITS-1:0] win_q [4];
  logic signed [SAMPLE_BITS-1:0] win_d [4];
  logic [SEEN_W-1:0]  seen_q, seen_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [LIMIT_W-1:0] count_q, count_d, count_inc;
  logic [RUN_W-1:0]   run_q, run_d;
  logic [UPC_W-1:0]   upc_q, upc_d;
  logic               done_q, done_d, busy_q, busy_d, final_q, final_d;

  mc_word_t           mw, ctrl;
  logic [PHASE_W:0]   phase_sum;
  logic               wrapped, hit_limit, e_end, e_last, e_cons;
  logic               in_fire, cfg_fire, out_free, emit_fire;
  logic signed [SAMPLE_BITS-1:0] y;

  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_value_q;
  logic [IDX_W-1:0]              out_index_q;
  logic                          out_last_q, out_end_q, out_consumed_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= STEP_RESET;
      limit_q <= LIMIT_W'(TABLE_DEPTH);
    end else if (cfg_fire) begin
      unique case (cfg_i.index)
        REG_PHASE_STEP:   step_q  <= cfg_i.data[STEP_W-1:0];
        REG_OUTPUT_LIMIT: limit_q <= cfg_i.data[LIMIT_W-1:0];
      endcase
    end
  end

  assign step_eff  = (step_q < MIN_STEP) ? MIN_STEP :
                     (step_q > STEP_W'(PHASE_ONE)) ? STEP_W'(PHASE_ONE) : step_q;
  assign limit_eff = (limit_q == '0) ? LIMIT_W'(1) :
                     (limit_q > LIMIT_W'(TABLE_DEPTH)) ? LIMIT_W'(TABLE_DEPTH) : limit_q;

  assign mw   = mc_rom(upc_q);
  assign ctrl = busy_q ? mw : MC_IDLE;

  hcr_datapath #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .win_i   (win_q),
    .phase_i (phase_q),
    .value_o (y)
  );

  assign phase_sum = {1'b0, phase_q} + step_eff;
  assign wrapped   = phase_sum[PHASE_W];
  assign count_inc = count_q + LIMIT_W'(1);
  assign hit_limit = count_inc >= limit_eff;
  assign e_end     = hit_limit || (wrapped && final_q);
  assign e_cons    = wrapped && final_q;
  assign e_last    = hit_limit || wrapped || (run_q == RUN_W'(MAX_RUN - 1));

  assign in_i.ready = !busy_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign emit_fire  = busy_q && (mw.op == OP_EMIT) && out_free;

  always_comb begin
    win_d   = win_q;
    seen_d  = seen_q;
    phase_d = phase_q;
    count_d = count_q;
    done_d  = done_q;
    busy_d  = busy_q;
    upc_d   = upc_q;
    run_d   = run_q;
    final_d = final_q;
    if (in_fire) begin
      if (in_i.first_sample) begin
        win_d   = '{default: '0};
        seen_d  = '0;
        phase_d = '0;
        count_d = '0;
        done_d  = 1'b0;
      end
      if (!done_d) begin
        win_d[0] = win_d[1];
        win_d[1] = win_d[2];
        win_d[2] = win_d[3];
        win_d[3] = in_i.sample_value;
        seen_d   = (seen_d == SEEN_FULL) ? SEEN_FULL : seen_d + SEEN_W'(1);
        if (seen_d != SEEN_FULL) begin
          done_d = in_i.final_sample;
        end else begin
          busy_d  = 1'b1;
          upc_d   = UPC_COEF;
          run_d   = '0;
          final_d = in_i.final_sample;
        end
      end
    end else if (busy_q && (mw.op != OP_EMIT || out_free)) begin
      if (mw.op == OP_EMIT) begin
        phase_d = phase_sum[PHASE_W-1:0];
        count_d = count_inc;
        run_d   = run_q + RUN_W'(1);
        if (e_end) begin
          done_d = 1'b1;
        end
      end
      unique case (mw.jump)
        JMP_NEXT: upc_d = upc_q + UPC_W'(1);
        JMP_LOOP: begin
          if (e_last) begin
            busy_d = 1'b0;
          end else begin
            upc_d = mw.target;
          end
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '{default: '0};
      seen_q  <= '0;
      phase_q <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
      busy_q  <= 1'b0;
      upc_q   <= UPC_COEF;
      run_q   <= '0;
      final_q <= 1'b0;
    end else begin
      win_q   <= win_d;
      seen_q  <= seen_d;
      phase_q <= phase_d;
      count_q <= count_d;
      done_q  <= done_d;
      busy_q  <= busy_d;
      upc_q   <= upc_d;
      run_q   <= run_d;
      final_q <= final_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_value_q    <= y;
      out_index_q    <= count_q[IDX_W-1:0];
      out_last_q     <= e_last;
      out_end_q      <= e_end;
      out_consumed_q <= e_cons;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.out_value       = out_value_q;
  assign out_o.out_index       = out_index_q;
  assign out_o.run_last        = out_last_q;
  assign out_o.table_end       = out_end_q;
  assign out_o.source_consumed = out_consumed_q;

`ifndef SYNTHESIS
  a_end_closes_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire && e_end |=> done_q && !busy_q)
    else $error("table end did not close the table");

  a_consumed_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_consumed_q |-> out_end_q && out_last_q)
    else $error("source_consumed set on a result that is not the table end");

  a_run_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire && (run_q == RUN_W'(MAX_RUN - 1)) |=> !busy_q)
    else $error("run exceeded its maximum length");
`endif

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import hcr_pkg::*;

  localparam int MAX_RUN  = MAX_RUN_DEF;
  localparam int MIN_STEP = (PHASE_ONE + MAX_RUN - 1) / MAX_RUN;
  localparam int DEPTH    = TABLE_DEPTH_DEF;

  typedef enum logic [1:0] {ROW_ITEM, ROW_STEP, ROW_LIMIT} row_e;
  typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_ONE} chk_e;

  typedef struct packed {
    logic signed [15:0] value;
    logic [11:0]        index;
    logic               last;
    logic               tbl_end;
    logic               consumed;
  } result_t;

  // For a CHK_ONE row the item causes a single result whose fields are typed in.
  typedef struct packed {
    row_e                  kind;
    logic [CFG_DATA_W-1:0] data;
    logic signed [15:0]    smp;
    logic                  first;
    logic                  fin;
    chk_e                  chk;
    logic signed [15:0]    val;
    logic [11:0]           idx;
    logic                  tend;
    logic                  cons;
  } row_t;

  localparam int NUM_ROWS = 34;
  localparam row_t DIRECTED [NUM_ROWS] = '{
    '{ROW_ITEM,  0,      100,    0, 0, CHK_NONE,    0,      0, 0, 0},
    '{ROW_ITEM,  0,      -32768, 0, 0, CHK_NONE,    0,      0, 0, 0},
    '{ROW_ITEM,  0,      32767,  0, 0, CHK_PREDICT, 0,      0, 0, 0},
    '{ROW_ITEM,  0,      -32768, 0, 0, CHK_PREDICT, 0,      0, 0, 0},
    '{ROW_STEP,  65536,  0,      0, 0, CHK_NONE,    0,      0, 0, 0},
    '{ROW_LIMIT, 5,      0,      0, 0, CHK_NONE,    0,      0, 0, 0},
    '{ROW_ITEM,  0,      -32768, 1, 0, CHK_NONE,    0,      0, 0, 0},
    '{ROW_ITEM,  0,      32767,  0, 0, CHK_NONE,    0,      0, 0, 0},
    '{ROW_ITEM,  0,      -32768, 0, 0, CHK_ONE,     -32768, 0, 0, 0},
    '{ROW_ITEM,  0,      12345,  0, 0, CHK_ONE,     32767,  1, 0, 0},
    '{ROW_ITEM,  0,      0,      0, 0, CHK_ONE,     -32768, 2, 0, 0},
    '{ROW_ITEM,  0,      -1,     0, 0, CHK_ONE,     12345,  3, 0, 0},
    '{ROW_ITEM,  0,      5,      0, 1, CHK_ONE,     0,      4, 1, 1},
    '{ROW_ITEM,  0,      77,     0, 0, CHK_NONE,    0,      0, 0, 0},
    '{ROW_ITEM,  0,      1000,   1, 0, CHK_NONE,    0,      0, 0, 0},
    '{ROW_ITEM,  0,      2000,   0, 1, CHK_NONE,    0,      0, 0, 0},
    '{ROW_ITEM,  0,      3000,   0, 0, CHK_NONE,    0,      0, 0, 0},
    '{ROW_ITEM,  0,      10,     1, 0, CHK_NONE,    0,      0, 0, 0},
    '{ROW_ITEM,  0,      20,     0, 0, CHK_NONE,    0,      0, 0, 0},
    '{ROW_ITEM,  0,      30,     0, 1, CHK_ONE,     10,     0, 1, 1},
    '{ROW_STEP,  131071, 0,      0, 0, CHK_NONE,    0,      0, 0, 0},
    '{ROW_LIMIT, 1,      0,      0, 0, CHK_NONE,    0,      0, 0, 0},
    '{ROW_ITEM,  0,      4,      1, 0, CHK_NONE,    0,      0, 0, 0},
    '{ROW_ITEM,  0,      8,      0, 0, CHK_NONE,    0,      0, 0, 0},
    '{ROW_ITEM,  0,      12,     0, 0, CHK_ONE,     4,      0, 1, 0},
    '{ROW_STEP,  0,      0,      0, 0, CHK_NONE,    0,      0, 0, 0},
    '{ROW_LIMIT, 0,      0,      0, 0, CHK_NONE,    0,      0, 0, 0},
    '{ROW_ITEM,  0,      1,      1, 0, CHK_NONE,    0,      0, 0, 0},
    '{ROW_ITEM,  0,      2,      0, 0, CHK_NONE,    0,      0, 0, 0},
    '{ROW_ITEM,  0,      3,      0, 0, CHK_ONE,     1,      0, 1, 0},
    '{ROW_LIMIT, 8191,   0,      0, 0, CHK_NONE,    0,      0, 0, 0},
    '{ROW_ITEM,  0,      -32768, 1, 0, CHK_NONE,    0,      0, 0, 0},
    '{ROW_ITEM,  0,      32767,  0, 0, CHK_NONE,    0,      0, 0, 0},
    '{ROW_ITEM,  0,      -32768, 0, 1, CHK_PREDICT, 0,      0, 0, 0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hcr_cfg_if                 cfg_if ();
  hcr_in_if  #(.SAMPLE_W(16)) in_if ();
  hcr_out_if #(.SAMPLE_W(16), .INDEX_W(12)) out_if ();

  hermite_cubic_resampler_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  result_t interp_due [$];
  int      mismatches = 0;
  int      results_seen = 0;
  int      taken = 0;
  logic    quiet = 1'b0;
  logic    long_hold = 1'b0;
  int      stall_left = 0;

  longint  win [4];
  int      ph;
  int      cnt;
  int      seen;
  bit      done;
  int      step_reg = int'(STEP_RESET);
  int      limit_reg = DEPTH;

  function automatic logic signed [15:0] hermite_point(input longint t, input longint xm1,
                                                       input longint x0, input longint x1,
                                                       input longint x2);
    longint c2, v, w2, a2, b2, s;
    c2 = x1 - xm1;
    v  = x0 - x1;
    w2 = c2 + 2 * v;
    a2 = w2 + 2 * v + (x2 - x0);
    b2 = w2 + a2;
    s  = ((a2 * t) >>> 8) - b2 * 256;
    s  = ((s * t) >>> 16) + c2 * 256;
    s  = ((s * t) >>> 16) + x0 * 512;
    s  = (s + 256) >>> 9;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return 16'(s);
  endfunction

  // Returns the number of results the item causes, or -1 when the item is ignored.
  function automatic int resample_item(input logic signed [15:0] smp, input logic first,
                                       input logic fin, input bit keep);
    int      st, lim, n;
    bit      wrapped, tend, cons, last;
    result_t res;
    if (first) begin
      win  = '{0, 0, 0, 0};
      ph   = 0;
      cnt  = 0;
      seen = 0;
      done = 1'b0;
    end
    if (done) return -1;
    win[0] = win[1];
    win[1] = win[2];
    win[2] = win[3];
    win[3] = longint'(smp);
    if (seen < 3) seen++;
    if (seen < 3) begin
      if (fin) done = 1'b1;
      return 0;
    end
    st  = step_reg;
    lim = limit_reg;
    if (st < MIN_STEP) st = MIN_STEP;
    if (st > PHASE_ONE) st = PHASE_ONE;
    if (lim < 1) lim = 1;
    if (lim > DEPTH) lim = DEPTH;
    n = 0;
    while (n < MAX_RUN) begin
      res.value = hermite_point(longint'(ph), win[0], win[1], win[2], win[3]);
      res.index = 12'(cnt);
      ph += st;
      wrapped = ph >= PHASE_ONE;
      if (wrapped) ph -= PHASE_ONE;
      cnt++;
      tend = 1'b0;
      cons = 1'b0;
      last = 1'b0;
      if (cnt >= lim) begin
        tend = 1'b1;
        cons = fin && wrapped;
        last = 1'b1;
      end else if (wrapped) begin
        last = 1'b1;
        if (fin) begin
          tend = 1'b1;
          cons = 1'b1;
        end
      end
      if (n == MAX_RUN - 1) last = 1'b1;
      res.last     = last;
      res.tbl_end  = tend;
      res.consumed = cons;
      if (keep) interp_due.push_back(res);
      n++;
      if (tend) done = 1'b1;
      if (last) break;
    end
    return n;
  endfunction

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (interp_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == REG_PHASE_STEP) step_reg = int'(data);
    else limit_reg = int'(data[12:0]);
  endtask

  task automatic offer(input logic signed [15:0] smp, input logic first, input logic fin);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_if.sample_value <= smp;
    in_if.first_sample <= first;
    in_if.final_sample <= fin;
    in_if.valid        <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  always @(posedge clk_i) begin
    if (long_hold) begin
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_if.ready <= 1'b0;
      stall_left = $urandom_range(1, 18) - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (interp_due.size() == 0) begin
        log_mismatch($sformatf("unexpected result: value %0d index %0d",
                               out_if.out_value, out_if.out_index));
      end else begin
        want = interp_due.pop_front();
        if (out_if.out_value !== want.value || out_if.out_index !== want.index ||
            out_if.run_last !== want.last || out_if.table_end !== want.tbl_end ||
            out_if.source_consumed !== want.consumed) begin
          log_mismatch($sformatf({"result %0d: expected %0d/%0d/%0b/%0b/%0b, ",
                                  "got %0d/%0d/%0b/%0b/%0b (value/index/last/end/consumed)"},
                                 results_seen, want.value, want.index, want.last,
                                 want.tbl_end, want.consumed, out_if.out_value,
                                 out_if.out_index, out_if.run_last, out_if.table_end,
                                 out_if.source_consumed));
        end
      end
      results_seen++;
    end
  end

  // The output side holds off long enough for the block to back up into its input.
  initial begin
    wait (taken >= 60);
    @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (600) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    row_t               r;
    int                 step_v, lim_v, batch, left, phase_no;
    bit                 paused;
    logic signed [15:0] smp;
    logic               first, fin;
    win = '{0, 0, 0, 0};
    ph = 0;
    cnt = 0;
    seen = 0;
    done = 1'b0;
    in_if.valid = 1'b0;
    in_if.sample_value = '0;
    in_if.first_sample = 1'b0;
    in_if.final_sample = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_PHASE_STEP;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_ROWS; i++) begin
      r = DIRECTED[i];
      case (r.kind)
        ROW_STEP: write_reg(REG_PHASE_STEP, r.data);
        ROW_LIMIT: write_reg(REG_OUTPUT_LIMIT, r.data);
        default: begin
          offer(r.smp, r.first, r.fin);
          void'(resample_item(r.smp, r.first, r.fin, r.chk == CHK_PREDICT));
          if (r.chk == CHK_ONE)
            interp_due.push_back(result_t'{r.val, r.idx, 1'b1, r.tend, r.cons});
        end
      endcase
    end

    phase_no = 0;
    paused = 1'b0;
    while (taken < 320) begin
      if (phase_no == 0) begin
        step_v = MIN_STEP;
        lim_v  = DEPTH;
      end else begin
        case ($urandom_range(0, 9))
          0: step_v = $urandom_range(0, MIN_STEP - 1);
          1: step_v = $urandom_range(PHASE_ONE + 1, 2 * PHASE_ONE - 1);
          2: step_v = PHASE_ONE;
          3, 4: step_v = $urandom_range(MIN_STEP, PHASE_ONE);
          default: step_v = $urandom_range(PHASE_ONE / 4, PHASE_ONE);
        endcase
        case ($urandom_range(0, 9))
          0: lim_v = 0;
          1: lim_v = $urandom_range(DEPTH + 1, 8191);
          2, 3, 4: lim_v = $urandom_range(1, 64);
          default: lim_v = DEPTH;
        endcase
      end
      write_reg(REG_PHASE_STEP, CFG_DATA_W'(step_v));
      write_reg(REG_OUTPUT_LIMIT, CFG_DATA_W'(lim_v));
      batch = (phase_no == 0) ? 70 : $urandom_range(20, 50);
      left = 0;
      for (int k = 0; k < batch; k++) begin
        first = 1'b0;
        if (left == 0) begin
          left  = (phase_no == 0) ? batch : $urandom_range(1, 24);
          first = 1'b1;
        end
        left--;
        fin = (left == 0) && ($urandom_range(0, 1) == 1);
        if ($urandom_range(0, 9) == 0) begin
          first = 1'($urandom_range(0, 1));
          fin   = 1'($urandom_range(0, 1));
        end
        case ($urandom_range(0, 7))
          0: smp = -16'sd32768;
          1: smp = 16'sd32767;
          default: smp = 16'($urandom);
        endcase
        offer(smp, first, fin);
        void'(resample_item(smp, first, fin, 1'b1));
        taken++;
        quiet <= (taken >= 290);
        if (!paused && taken >= 150) begin
          paused = 1'b1;
          in_if.valid <= 1'b0;
          while (interp_due.size() != 0) @(posedge clk_i);
        end
      end
      phase_no++;
    end

    in_if.valid <= 1'b0;
    while (interp_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && interp_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
